/* rtl/sha1_pkg.sv */
// Package with shared types and constants of the SHA-1 message hasher.
package sha1_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam int QDEPTH = 2;

  // One queued transaction from the front end to the core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

endpackage

/* rtl/sha1_queue.sv */
// Short queue between the intake front end and the hashing core.
module sha1_queue
  import sha1_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != QDEPTH[$clog2(QDEPTH):0]);
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* rtl/sha1_front.sv */
// Intake front end: drops empty non-final items and forwards the rest.
module sha1_front
  import sha1_pkg::*;
(
  input  logic  in_valid,
  output logic  in_ready,
  input  logic [7:0] in_data_byte,
  input  logic  in_byte_present,
  input  logic  in_end_of_message,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  logic useful;

  // An item with no byte and no end mark changes nothing.
  assign useful   = in_byte_present || in_end_of_message;
  assign in_ready = q_ready || !useful;
  assign q_valid  = in_valid && useful;
  assign q_item   = '{data_byte: in_data_byte, byte_present: in_byte_present,
                      end_of_message: in_end_of_message};

endmodule

/* rtl/sha1_core.sv */
// Hashing core: byte packing, padding, 80-round compression and digest output.
module sha1_core
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_h0,
  output logic [31:0] out_digest_h1,
  output logic [31:0] out_digest_h2,
  output logic [31:0] out_digest_h3,
  output logic [31:0] out_digest_h4
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ROUND = 6'b000100,
    S_FOLD  = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [60:0] total_r;
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        fin_r;      // Final item in progress.
  logic        lenblk_r;   // Current compression carries the length.
  logic [5:0]  ppos_r;     // Position for the 0x80 byte.
  logic        ovf_r;      // 0x80 landed at 56 or later.
  logic [31:0] dig_r [5];
  logic        ov_r;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [1:0]  bi;
  logic [31:0] wt, fv, kv, tmp, wx;
  logic        take;
  logic [63:0] bits;

  assign pos   = total_r[5:0];
  assign wi    = pos[5:2];
  assign bi    = pos[1:0];
  assign take  = q_valid && q_ready;
  assign q_ready = (state_r == S_IDLE) && !(q_item.end_of_message && ov_r);
  assign bits  = {total_r, 3'b000};

  // Round function for the current round.
  always_comb begin
    wx = w_r[(rnd_r[3:0] + 4'd13)] ^ w_r[(rnd_r[3:0] + 4'd8)] ^
         w_r[(rnd_r[3:0] + 4'd2)] ^ w_r[rnd_r[3:0]];
    wt = (rnd_r >= 7'd16) ? {wx[30:0], wx[31]} : w_r[rnd_r[3:0]];
    if (rnd_r < 7'd20) begin
      fv = (b_r & c_r) | (~b_r & d_r);
      kv = K0;
    end else if (rnd_r < 7'd40) begin
      fv = b_r ^ c_r ^ d_r;
      kv = K1;
    end else if (rnd_r < 7'd60) begin
      fv = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      kv = K2;
    end else begin
      fv = b_r ^ c_r ^ d_r;
      kv = K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + fv + e_r + kv + wt;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (q_item.byte_present && pos == 6'd63) state_nxt = S_ROUND;
          else if (q_item.end_of_message) state_nxt = S_PAD;
        end
      end
      S_PAD:   state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 7'd79) state_nxt = S_FOLD;
      S_FOLD: begin
        if (!fin_r) state_nxt = S_IDLE;
        else if (lenblk_r) state_nxt = S_OUT;
        else if (ovf_r) state_nxt = S_LEN;
        else state_nxt = S_PAD;
      end
      S_LEN:   state_nxt = S_ROUND;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
      ov_r     <= 1'b0;
      h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (q_item.byte_present) total_r <= total_r + 61'd1;
            fin_r    <= q_item.end_of_message;
            lenblk_r <= 1'b0;
          end
        end
        S_PAD: begin
          // Padding of the pending block; length goes in when it fits.
          lenblk_r <= !ovf_r;
          rnd_r    <= '0;
        end
        S_LEN: begin
          lenblk_r <= 1'b1;
          rnd_r    <= '0;
        end
        S_ROUND: rnd_r <= (rnd_r == 7'd79) ? 7'd0 : rnd_r + 7'd1;
        S_FOLD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
        end
        S_OUT: begin
          fin_r   <= 1'b0;
          total_r <= '0;
          h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (take && q_item.byte_present) begin
          case (bi)
            2'd0: w_r[wi] <= {q_item.data_byte, 24'd0};
            2'd1: w_r[wi][23:16] <= q_item.data_byte;
            2'd2: w_r[wi][15:8] <= q_item.data_byte;
            default: w_r[wi][7:0] <= q_item.data_byte;
          endcase
        end
        if (take) begin
          ppos_r <= q_item.byte_present ? pos + 6'd1 : pos;
          ovf_r  <= (q_item.byte_present ? pos + 6'd1 : pos) >= LEN_POS;
        end
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
      S_PAD: begin
        // 0x80 at the pad position, zeros after, length if it fits.
        for (int k = 0; k < 16; k++) begin
          if (!ovf_r && k >= 14) begin
            w_r[k] <= (k == 14) ? bits[63:32] : bits[31:0];
          end else if (ppos_r[5:2] == k[3:0]) begin
            case (ppos_r[1:0])
              2'd0: w_r[k] <= {PAD_BYTE, 24'd0};
              2'd1: w_r[k] <= {w_r[k][31:24], PAD_BYTE, 16'd0};
              2'd2: w_r[k] <= {w_r[k][31:16], PAD_BYTE, 8'd0};
              default: w_r[k] <= {w_r[k][31:8], PAD_BYTE};
            endcase
          end else if (k[3:0] > ppos_r[5:2]) begin
            w_r[k] <= '0;
          end
        end
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
      S_LEN: begin
        for (int k = 0; k < 14; k++) w_r[k] <= '0;
        w_r[14] <= bits[63:32];
        w_r[15] <= bits[31:0];
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
      S_ROUND: begin
        if (rnd_r >= 7'd16) w_r[rnd_r[3:0]] <= wt;
        e_r <= d_r;
        d_r <= c_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        b_r <= a_r;
        a_r <= tmp;
      end
      S_OUT: begin
        for (int k = 0; k < 5; k++) dig_r[k] <= h_r[k];
      end
      default: ;
    endcase
  end

  assign out_valid     = ov_r;
  assign out_digest_h0 = dig_r[0];
  assign out_digest_h1 = dig_r[1];
  assign out_digest_h2 = dig_r[2];
  assign out_digest_h3 = dig_r[3];
  assign out_digest_h4 = dig_r[4];

endmodule

/* rtl/sha1_message_hasher.sv */
// Streaming SHA-1 hasher: byte intake, queue, and compression core.
// A byte that completes a 64-byte block starts a compression in the core
// (80 rounds, one per cycle on the single round unit, plus load and fold).
// Other bytes are only packed, and no item is taken during a compression.
// A final item adds a padding block, and a length block if the length spills.
// The digest is held in an output register until taken.
// Reset (synchronous, active low) restores the initial chaining values.
module sha1_message_hasher
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_h0,
  output logic [31:0] out_digest_h1,
  output logic [31:0] out_digest_h2,
  output logic [31:0] out_digest_h3,
  output logic [31:0] out_digest_h4
);

  logic  fq_valid, fq_ready, qc_valid, qc_ready;
  item_t fq_item, qc_item;

  sha1_front u_front (
    .in_valid, .in_ready, .in_data_byte, .in_byte_present, .in_end_of_message,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  sha1_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(qc_valid), .rd_ready(qc_ready), .rd_item(qc_item)
  );

  sha1_core u_core (
    .clk, .rst_n,
    .q_valid(qc_valid), .q_ready(qc_ready), .q_item(qc_item),
    .out_valid, .out_ready,
    .out_digest_h0, .out_digest_h1, .out_digest_h2, .out_digest_h3, .out_digest_h4
  );

endmodule
